### design/rgb_tone_pixel_converter_unit_macros.svh
// Assertion macros shared by the checker of the tone pixel converter.
// No dependencies; included by files that hold concurrent assertions.
`ifndef RGB_TONE_PIXEL_CONVERTER_UNIT_MACROS_SVH
`define RGB_TONE_PIXEL_CONVERTER_UNIT_MACROS_SVH

// Implication checked only outside reset.
`define RTPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next cycle, checked only outside reset.
`define RTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked at every edge, reset included.
`define RTPC_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

### design/rtpc_pkg.sv
// Types, codes and RGB332 expansion functions of the tone pixel converter.
// No dependencies; used by the top level, front end, back end, checker and testbench.
package rtpc_pkg;

    localparam int RB_W  = 5;
    localparam int G_W   = 6;
    localparam int PIX_W = 16;

    typedef enum logic [1:0] {
        KIND_LOAD5  = 2'd0,
        KIND_LOAD6  = 2'd1,
        KIND_RGB332 = 2'd2,
        KIND_RGB565 = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [G_W-1:0]    idx;
        logic [G_W-1:0]    val;
        logic [PIX_W-1:0]  pix;
    } op_t;

    // r * 31 / 7, truncated
    function automatic logic [RB_W-1:0] expand_red(input logic [2:0] r);
        logic [RB_W-1:0] e;
        case (r)
            3'd0: e = 5'd0;
            3'd1: e = 5'd4;
            3'd2: e = 5'd8;
            3'd3: e = 5'd13;
            3'd4: e = 5'd17;
            3'd5: e = 5'd22;
            3'd6: e = 5'd26;
            default: e = 5'd31;
        endcase
        return e;
    endfunction

    // g * 63 / 7, truncated
    function automatic logic [G_W-1:0] expand_green(input logic [2:0] g);
        logic [G_W-1:0] e;
        case (g)
            3'd0: e = 6'd0;
            3'd1: e = 6'd9;
            3'd2: e = 6'd18;
            3'd3: e = 6'd27;
            3'd4: e = 6'd36;
            3'd5: e = 6'd45;
            3'd6: e = 6'd54;
            default: e = 6'd63;
        endcase
        return e;
    endfunction

    // b * 31 / 3, truncated
    function automatic logic [RB_W-1:0] expand_blue(input logic [1:0] b);
        logic [RB_W-1:0] e;
        case (b)
            2'd0: e = 5'd0;
            2'd1: e = 5'd10;
            2'd2: e = 5'd20;
            default: e = 5'd31;
        endcase
        return e;
    endfunction

endpackage

### design/rgb_tone_pixel_converter_unit.sv
// Top level of the tone pixel converter: front end, op queue, back end, result queue.
// Depends on rtpc_pkg, rtpc_front, rtpc_fifo and rtpc_back.
//
// Takes one item per clock while full is low and, with pop held high, delivers one
// result per clock. A convert item's result goes to pixel_out in order: its transfer
// edge writes the op queue, the edge that pops the op registers the table read, and
// a later edge writes the result queue. The tone tables start as identity after
// reset and need no clearing pass. Loads are applied in order with converts, so a
// convert always sees every earlier load. full rises when QUEUE_DEPTH ops wait behind
// a stalled back end.
module rgb_tone_pixel_converter_unit #(
    parameter int QUEUE_DEPTH = 4,
    parameter int OUT_DEPTH   = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [5:0]  table_index,
    input  logic [5:0]  table_value,
    input  logic [15:0] pixel_value,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] pixel_out
);
    import rtpc_pkg::*;

    op_t               front_op;
    op_t               q_op;
    logic              q_empty;
    logic              q_pop;
    logic              res_full;
    logic              res_push;
    logic [PIX_W-1:0]  res_pixel;

    rtpc_front u_front (
        .kind        (kind),
        .table_index (table_index),
        .table_value (table_value),
        .pixel_value (pixel_value),
        .op          (front_op)
    );

    rtpc_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .data_in  (front_op),
        .full     (full),
        .pop      (q_pop),
        .data_out (q_op),
        .empty    (q_empty)
    );

    rtpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_op      (q_op),
        .q_pop     (q_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_pixel (res_pixel)
    );

    rtpc_fifo #(
        .WIDTH (PIX_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .data_in  (res_pixel),
        .full     (res_full),
        .pop      (pop),
        .data_out (pixel_out),
        .empty    (empty)
    );

endmodule

### design/rtpc_fifo.sv
// Small register-based first-in first-out queue with count, full and empty.
// No package dependencies; used for the op queue and the result queue.
module rtpc_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] data_in,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] data_out,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push_ok;
    logic             pop_ok;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign push_ok  = push && !full;
    assign pop_ok   = pop && !empty;
    assign data_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

### design/rtpc_front.sv
// Front end: classifies an incoming item and expands RGB332 pixels to RGB565.
// Depends on rtpc_pkg for the op type, kind codes and expansion functions.
module rtpc_front (
    input  logic [1:0]      kind,
    input  logic [5:0]      table_index,
    input  logic [5:0]      table_value,
    input  logic [15:0]     pixel_value,
    output rtpc_pkg::op_t   op
);
    import rtpc_pkg::*;

    kind_t k;

    assign k = kind_t'(kind);

    always_comb
    begin
        op.kind = k;
        op.idx  = table_index;
        op.val  = table_value;
        op.pix  = pixel_value;
        case (k)
            KIND_LOAD5:
            begin
                op.idx = {1'b0, table_index[RB_W-1:0]};
                op.val = {1'b0, table_value[RB_W-1:0]};
            end
            KIND_LOAD6:
            begin
                op.idx = table_index;
            end
            KIND_RGB332:
            begin
                op.pix = {expand_red(pixel_value[7:5]),
                          expand_green(pixel_value[4:2]),
                          expand_blue(pixel_value[1:0])};
            end
            default:
            begin
                op.pix = pixel_value;
            end
        endcase
    end

endmodule

### design/rtpc_back.sv
// Back end: holds both tone tables, applies loads and looks up converts.
// Depends on rtpc_pkg for the op type and kind codes.
module rtpc_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  rtpc_pkg::op_t             q_op,
    output logic                      q_pop,
    input  logic                      res_full,
    output logic                      res_push,
    output logic [rtpc_pkg::PIX_W-1:0] res_pixel
);
    import rtpc_pkg::*;

    localparam int RB_DEPTH = 1 << RB_W;
    localparam int G_DEPTH  = 1 << G_W;

    logic [RB_W-1:0]     tone5_mem [RB_DEPTH];
    logic [G_W-1:0]      tone6_mem [G_DEPTH];
    logic [RB_DEPTH-1:0] valid5_reg;
    logic [G_DEPTH-1:0]  valid6_reg;

    logic                busy_reg, busy_next;
    logic [RB_W-1:0]     r_data_reg, b_data_reg;
    logic [G_W-1:0]      g_data_reg;
    logic [RB_W-1:0]     r_idx_reg, b_idx_reg;
    logic [G_W-1:0]      g_idx_reg;
    logic                r_vld_reg, g_vld_reg, b_vld_reg;

    logic                advance;
    logic                wr5, wr6, conv;
    logic [RB_W-1:0]     r_idx, b_idx;
    logic [G_W-1:0]      g_idx;

    assign res_push = busy_reg && !res_full;
    assign advance  = !busy_reg || !res_full;
    assign q_pop    = !q_empty && advance;
    assign wr5      = q_pop && (q_op.kind == KIND_LOAD5);
    assign wr6      = q_pop && (q_op.kind == KIND_LOAD6);
    assign conv     = q_pop && ((q_op.kind == KIND_RGB332) || (q_op.kind == KIND_RGB565));

    assign r_idx = q_op.pix[PIX_W-1 -: RB_W];
    assign g_idx = q_op.pix[RB_W +: G_W];
    assign b_idx = q_op.pix[RB_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        if (conv)
        begin
            busy_next = 1'b1;
        end
        else if (res_push)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            valid5_reg <= '0;
            valid6_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (wr5)
            begin
                valid5_reg[q_op.idx[RB_W-1:0]] <= 1'b1;
            end
            if (wr6)
            begin
                valid6_reg[q_op.idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr5)
        begin
            tone5_mem[q_op.idx[RB_W-1:0]] <= q_op.val[RB_W-1:0];
        end
        if (wr6)
        begin
            tone6_mem[q_op.idx] <= q_op.val;
        end
        if (conv)
        begin
            r_data_reg <= tone5_mem[r_idx];
            b_data_reg <= tone5_mem[b_idx];
            g_data_reg <= tone6_mem[g_idx];
            r_vld_reg  <= valid5_reg[r_idx];
            b_vld_reg  <= valid5_reg[b_idx];
            g_vld_reg  <= valid6_reg[g_idx];
            r_idx_reg  <= r_idx;
            b_idx_reg  <= b_idx;
            g_idx_reg  <= g_idx;
        end
    end

    // an unwritten entry reads as its own index
    assign res_pixel = {r_vld_reg ? r_data_reg : r_idx_reg,
                        g_vld_reg ? g_data_reg : g_idx_reg,
                        b_vld_reg ? b_data_reg : b_idx_reg};

endmodule

### design/rtpc_checker.sv
// Port-level checker for the tone pixel converter, bound to the top level.
// Depends on rgb_tone_pixel_converter_unit_macros.svh for the assertion macros.
`include "rgb_tone_pixel_converter_unit_macros.svh"

module rtpc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  kind,
    input  logic        empty,
    input  logic        pop,
    input  logic [15:0] pixel_out
);
    import rtpc_pkg::*;

    logic [7:0] pending_reg, pending_next;
    logic       conv_in;
    logic       res_out;
    logic       rst_prev_reg = 1'b0;

    assign conv_in = push && !full && ((kind == KIND_RGB332) || (kind == KIND_RGB565));
    assign res_out = pop && !empty;

    always_comb
    begin
        pending_next = pending_reg;
        if (conv_in && !res_out)
        begin
            pending_next = pending_reg + 8'd1;
        end
        else if (res_out && !conv_in)
        begin
            pending_next = pending_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // reset already low at the previous edge, so the queues have been cleared
    always_ff @(posedge clk)
    begin
        rst_prev_reg <= !rst_n;
    end

    `RTPC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n && rst_prev_reg, empty && !full, "queues not clear in reset")
    `RTPC_ASSERT_IMPL(a_no_extra_result, clk, rst_n, !empty, pending_reg != 8'd0, "result without convert")
    `RTPC_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(pixel_out), "waiting result changed")

endmodule

bind rgb_tone_pixel_converter_unit rtpc_checker u_rtpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .empty     (empty),
    .pop       (pop),
    .pixel_out (pixel_out)
);

### tb/rgb_tone_pixel_converter_unit_tb.sv
// Self-checking testbench for rgb_tone_pixel_converter_unit: table loads and pixel converts
// are checked against an in-bench tone table model under random idling and back-pressure.
// Depends on rtpc_pkg and the rgb_tone_pixel_converter_unit RTL.
module rgb_tone_pixel_converter_unit_tb;

    import rtpc_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  idx;
        logic [5:0]  val;
        logic [15:0] pix;
        logic        fixed;
        logic [15:0] px;
    } tone_row_t;

    localparam int N_ROWS = 20;
    localparam int N_RAND = 1630;
    localparam int HOLD_CYCLES = 300;

    localparam tone_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{KIND_RGB565, 6'd0,  6'd0,  16'h0000, 1'b1, 16'h0000},
        '{KIND_RGB565, 6'd0,  6'd0,  16'hFFFF, 1'b1, 16'hFFFF},
        '{KIND_RGB332, 6'd0,  6'd0,  16'h00FF, 1'b1, 16'hFFFF},
        '{KIND_RGB332, 6'd63, 6'd63, 16'hFF00, 1'b1, 16'h0000},
        '{KIND_RGB565, 6'd63, 6'd63, 16'hA5C3, 1'b1, 16'hA5C3},
        '{KIND_RGB332, 6'd21, 6'd42, 16'h5A49, 1'b0, 16'h0000},
        '{KIND_RGB332, 6'd0,  6'd0,  16'h00B6, 1'b0, 16'h0000},
        '{KIND_LOAD5,  6'd63, 6'd63, 16'hFFFF, 1'b0, 16'h0000},
        '{KIND_LOAD5,  6'd32, 6'd33, 16'h0000, 1'b0, 16'h0000},
        '{KIND_LOAD5,  6'd31, 6'd32, 16'hFFFF, 1'b0, 16'h0000},
        '{KIND_LOAD6,  6'd63, 6'd0,  16'h0000, 1'b0, 16'h0000},
        '{KIND_LOAD6,  6'd0,  6'd63, 16'hFFFF, 1'b0, 16'h0000},
        '{KIND_RGB565, 6'd0,  6'd0,  16'h0000, 1'b0, 16'h0000},
        '{KIND_RGB565, 6'd0,  6'd0,  16'hFFFF, 1'b0, 16'h0000},
        '{KIND_RGB332, 6'd0,  6'd0,  16'hFF00, 1'b0, 16'h0000},
        '{KIND_RGB332, 6'd0,  6'd0,  16'h00FF, 1'b0, 16'h0000},
        '{KIND_LOAD6,  6'd21, 6'd42, 16'h1234, 1'b0, 16'h0000},
        '{KIND_LOAD5,  6'd10, 6'd21, 16'h0000, 1'b0, 16'h0000},
        '{KIND_RGB565, 6'd0,  6'd0,  16'h52AA, 1'b0, 16'h0000},
        '{KIND_RGB332, 6'd0,  6'd0,  16'h0025, 1'b0, 16'h0000}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    kind_t       kind = KIND_LOAD5;
    logic [5:0]  table_index = '0;
    logic [5:0]  table_value = '0;
    logic [15:0] pixel_value = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] pixel_out;

    logic        fixed_exp = 1'b0;
    logic [15:0] fixed_px = '0;

    logic [4:0]  red_blue_tone [32];
    logic [5:0]  green_tone [64];
    logic [15:0] toned_px_q [$];
    int          tone_errors = 0;

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    bit rx_hold_req = 1'b0;

    rgb_tone_pixel_converter_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .table_index (table_index),
        .table_value (table_value),
        .pixel_value (pixel_value),
        .empty       (empty),
        .pop         (pop),
        .pixel_out   (pixel_out)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        for (int i = 0; i < 32; i++)
        begin
            red_blue_tone[i] = 5'(i);
        end
        for (int i = 0; i < 64; i++)
        begin
            green_tone[i] = 6'(i);
        end
    end

    function automatic logic [15:0] predict_toned_pixel(input kind_t k, input logic [15:0] px);
        logic [15:0] src;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        if (k == KIND_RGB332)
        begin
            r = px[7:5];
            g = px[4:2];
            b = px[1:0];
            r = r * 31 / 7;
            g = g * 63 / 7;
            b = b * 31 / 3;
            src = {r[4:0], g[5:0], b[4:0]};
        end
        else
        begin
            src = px;
        end
        return {red_blue_tone[src[15:11]], green_tone[src[10:5]], red_blue_tone[src[4:0]]};
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        tone_errors++;
    endtask

    // transfers in update the tables or queue an expected pixel; transfers out are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (toned_px_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected pixel_out %h", pixel_out));
                end
                else if (pixel_out !== toned_px_q[0])
                begin
                    report_mismatch($sformatf("pixel_out %h, expected %h",
                                              pixel_out, toned_px_q[0]));
                    void'(toned_px_q.pop_front());
                end
                else
                begin
                    void'(toned_px_q.pop_front());
                end
            end
            if (push && !full)
            begin
                case (kind)
                    KIND_LOAD5:
                    begin
                        red_blue_tone[table_index[4:0]] <= table_value[4:0];
                    end
                    KIND_LOAD6:
                    begin
                        green_tone[table_index] <= table_value;
                    end
                    default:
                    begin
                        toned_px_q.push_back(fixed_exp ? fixed_px
                                                       : predict_toned_pixel(kind, pixel_value));
                    end
                endcase
            end
        end
    end

    task automatic send_item(input tone_row_t row);
        if (!tx_calm && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        push        <= 1'b1;
        kind        <= row.kind;
        table_index <= row.idx;
        table_value <= row.val;
        pixel_value <= row.pix;
        fixed_exp   <= row.fixed;
        fixed_px    <= row.px;
        do @(posedge clk); while (full);
    endtask

    function automatic tone_row_t random_item();
        tone_row_t row;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        row.kind  = (pick == 0) ? KIND_LOAD5 : (pick == 1) ? KIND_LOAD6 :
                    (pick < 6) ? KIND_RGB332 : KIND_RGB565;
        row.idx   = 6'($urandom);
        row.val   = 6'($urandom);
        row.pix   = 16'($urandom);
        row.fixed = 1'b0;
        row.px    = '0;
        return row;
    endfunction

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (toned_px_q.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_ROWS; i++)
        begin
            send_item(DIRECTED_ROWS[i]);
        end
        for (int i = 0; i < N_RAND; i++)
        begin
            if (i == 500)
            begin
                rx_hold_req = 1'b1;
            end
            if (i == 1000)
            begin
                wait_drained();
            end
            if (i == 1300)
            begin
                tx_calm = 1'b1;
                rx_calm = 1'b1;
            end
            send_item(random_item());
        end
        wait_drained();
        repeat (8) @(posedge clk);
        if (toned_px_q.size() != 0)
        begin
            report_mismatch("expected pixels left over");
        end
        if (tone_errors == 0)
        begin
            $display("rgb_tone_pixel_converter_unit_tb: clean");
        end
        else
        begin
            $display("rgb_tone_pixel_converter_unit_tb: errors");
        end
        $finish;
    end

    // receiver: random stalls, one long hold-off to fill the block, then steady draining
    initial
    begin
        int hold_cnt;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                pop <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    hold_cnt++;
                end
                rx_hold_req = 1'b0;
            end
            else if (rx_calm)
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("rgb_tone_pixel_converter_unit_tb: errors");
        $finish;
    end

endmodule
